// ===== rtl/tfqs_pkg.sv =====
package tfqs_pkg;

    // Field widths
    localparam int HASH_W  = 32;
    localparam int WORD_W  = 32;
    localparam int PORT_W  = 16;
    localparam int QUEUE_W = 6;
    localparam int LG_W    = 4;
    localparam int QCNT_W  = 7;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_KEY0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LOCAL_IP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_LG = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_QCOUNT   = 3'd6;

    // Reset values
    localparam logic [WORD_W-1:0] KEY0_RESET = 32'h8219FA80;
    localparam logic [WORD_W-1:0] KEY1_RESET = 32'hA4310659;
    localparam logic [WORD_W-1:0] KEY2_RESET = 32'h3E3F9AAC;
    localparam logic [WORD_W-1:0] KEY3_RESET = 32'h3DAED6D9;
    localparam logic [LG_W-1:0]   TABLE_LG_RESET = 4'd11;
    localparam logic [QCNT_W-1:0] QCOUNT_RESET   = 7'd1;

    // XOR of the key windows picked by the set bits of one tuple word.
    // Bit b (LSB index) selects the window pair[b+32:b+1].
    function automatic logic [HASH_W-1:0] hash_word(
        input logic [WORD_W-1:0] word,
        input logic [WORD_W-1:0] key_hi,
        input logic [WORD_W-1:0] key_lo
    );
        logic [2*WORD_W-1:0] pair;
        logic [HASH_W-1:0]   acc;
        pair = {key_hi, key_lo};
        acc  = '0;
        for (int b = 0; b < WORD_W; b++)
        begin
            if (word[b])
            begin
                acc = acc ^ pair[b+1 +: HASH_W];
            end
        end
        return acc;
    endfunction

endpackage

// ===== rtl/tfqs_mod_pipe.sv =====
module tfqs_mod_pipe
    import tfqs_pkg::*;
#(
    parameter int TW = 11,
    parameter int QW = 7
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [QW-1:0]     qc,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [HASH_W-1:0] in_hash,
    input  logic [TW-1:0]     in_dividend,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [HASH_W-1:0] out_hash,
    output logic [QW-1:0]     out_rem
);

    // One restoring step per stage, dividend MSB first
    logic              valid_reg [TW];
    logic [QW-1:0]     rem_reg   [TW];
    logic [TW-1:0]     div_reg   [TW];
    logic [HASH_W-1:0] hash_reg  [TW];
    logic              adv       [TW];

    genvar k;
    generate
        for (k = 0; k < TW; k++)
        begin : g_stage
            logic              src_valid;
            logic [QW-1:0]     src_rem;
            logic [TW-1:0]     src_div;
            logic [HASH_W-1:0] src_hash;
            logic [QW:0]       trial;
            logic [QW-1:0]     rem_next;

            if (k == 0)
            begin : g_first
                assign src_valid = in_valid;
                assign src_rem   = '0;
                assign src_div   = in_dividend;
                assign src_hash  = in_hash;
            end
            else
            begin : g_chain
                assign src_valid = valid_reg[k-1];
                assign src_rem   = rem_reg[k-1];
                assign src_div   = div_reg[k-1];
                assign src_hash  = hash_reg[k-1];
            end

            // Stage can take a request when empty or when its own moves on
            if (k == TW - 1)
            begin : g_last_adv
                assign adv[k] = !valid_reg[k] || !out_stall;
            end
            else
            begin : g_mid_adv
                assign adv[k] = !valid_reg[k] || adv[k+1];
            end

            // Shift in one dividend bit, subtract divisor if it fits
            always_comb
            begin
                trial = {src_rem, src_div[TW-1-k]};
                if (trial >= {1'b0, qc})
                begin
                    rem_next = QW'(trial - {1'b0, qc});
                end
                else
                begin
                    rem_next = QW'(trial);
                end
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    valid_reg[k] <= 1'b0;
                end
                else if (adv[k])
                begin
                    valid_reg[k] <= src_valid;
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv[k] && src_valid)
                begin
                    rem_reg[k]  <= rem_next;
                    div_reg[k]  <= src_div;
                    hash_reg[k] <= src_hash;
                end
            end
        end
    endgenerate

    assign in_stall  = !adv[0];
    assign out_valid = valid_reg[TW-1];
    assign out_hash  = hash_reg[TW-1];
    assign out_rem   = rem_reg[TW-1];

endmodule

// ===== rtl/toeplitz_flow_queue_select.sv =====
// Toeplitz flow hash and receive queue select.
// Pipeline from accepted request to result: hash stage, XOR/mask stage,
// then one restoring modulo step per table bit.
// Throughput: one request per cycle; every stage holds in place under stall.
// Reset: asynchronous active-low rst_n clears all valid bits and loads the
// default key, local_ip 0, table_log2 11 and queue_count 1.
module toeplitz_flow_queue_select
    import tfqs_pkg::*;
#(
    parameter int MAX_QUEUES     = 64,
    parameter int MAX_TABLE_LOG2 = 11
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write channel
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    // flow request channel
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_W-1:0]    remote_ip,
    input  logic [PORT_W-1:0]    remote_port,
    input  logic [PORT_W-1:0]    own_port,
    // result channel
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [HASH_W-1:0]    hash_value,
    output logic [QUEUE_W-1:0]   queue_index
);

    localparam int TW = (MAX_TABLE_LOG2 == 0) ? 1 : MAX_TABLE_LOG2;
    localparam int QW = $clog2(MAX_QUEUES + 1);
    localparam logic [4:0] MAX_LG = 5'(MAX_TABLE_LOG2);
    localparam logic [8:0] MAX_QC = 9'(MAX_QUEUES);

    // Configuration registers
    logic [WORD_W-1:0] key0_reg, key1_reg, key2_reg, key3_reg;
    logic [WORD_W-1:0] local_ip_reg;
    logic [LG_W-1:0]   table_lg_reg;
    logic [QCNT_W-1:0] qcount_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg     <= KEY0_RESET;
            key1_reg     <= KEY1_RESET;
            key2_reg     <= KEY2_RESET;
            key3_reg     <= KEY3_RESET;
            local_ip_reg <= '0;
            table_lg_reg <= TABLE_LG_RESET;
            qcount_reg   <= QCOUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_KEY0:     key0_reg     <= cfg_data;
                CFG_KEY1:     key1_reg     <= cfg_data;
                CFG_KEY2:     key2_reg     <= cfg_data;
                CFG_KEY3:     key3_reg     <= cfg_data;
                CFG_LOCAL_IP: local_ip_reg <= cfg_data;
                CFG_TABLE_LG: table_lg_reg <= cfg_data[LG_W-1:0];
                CFG_QCOUNT:   qcount_reg   <= cfg_data[QCNT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Effective table size and queue count, saturated; a queue count of 0 is taken as 1
    logic [4:0]    lg_eff;
    logic [8:0]    qc_wide;
    logic [QW-1:0] qc_eff;

    always_comb
    begin
        if ({1'b0, table_lg_reg} > MAX_LG)
        begin
            lg_eff = MAX_LG;
        end
        else
        begin
            lg_eff = {1'b0, table_lg_reg};
        end

        qc_wide = {2'b00, qcount_reg};
        if (qc_wide == 9'd0)
        begin
            qc_eff = QW'(1);
        end
        else if (qc_wide > MAX_QC)
        begin
            qc_eff = QW'(MAX_QC);
        end
        else
        begin
            qc_eff = QW'(qc_wide);
        end
    end

    // Stage handshake
    logic a_valid_reg, b_valid_reg;
    logic a_adv, b_adv;
    logic mp_stall;

    assign b_adv    = !b_valid_reg || !mp_stall;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_stall = !a_adv;

    // Stage A: per-word key window XOR
    logic [HASH_W-1:0] h0_reg, h1_reg, h2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (a_adv)
        begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_adv && in_valid)
        begin
            h0_reg <= hash_word(remote_ip, key0_reg, key1_reg);
            h1_reg <= hash_word(local_ip_reg, key1_reg, key2_reg);
            h2_reg <= hash_word({remote_port, own_port}, key2_reg, key3_reg);
        end
    end

    // Stage B: combine and mask to the table size
    logic [HASH_W-1:0] hash_next;
    logic [TW-1:0]     masked_next;
    logic [HASH_W-1:0] hash_reg;
    logic [TW-1:0]     masked_reg;

    always_comb
    begin
        hash_next = h0_reg ^ h1_reg ^ h2_reg;
        for (int i = 0; i < TW; i++)
        begin
            masked_next[i] = hash_next[i] && (5'(i) < lg_eff);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (b_adv)
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_adv && a_valid_reg)
        begin
            hash_reg   <= hash_next;
            masked_reg <= masked_next;
        end
    end

    // Modulo by queue count
    logic [QW-1:0] rem;

    tfqs_mod_pipe #(
        .TW (TW),
        .QW (QW)
    ) u_mod (
        .clk         (clk),
        .rst_n       (rst_n),
        .qc          (qc_eff),
        .in_valid    (b_valid_reg),
        .in_stall    (mp_stall),
        .in_hash     (hash_reg),
        .in_dividend (masked_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_hash    (hash_value),
        .out_rem     (rem)
    );

    assign queue_index = QUEUE_W'(rem);

endmodule

// ===== verif/toeplitz_flow_queue_select_test.sv =====
`timescale 1ns / 100ps

module toeplitz_flow_queue_select_test;
    import tfqs_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int DRAIN_WAIT  = 20;     // pipeline is 13 deep, plus margin
    localparam int QUIET_LIMIT = 4000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES = 90;     // long result back-pressure stretch
    localparam int PHASES      = 12;
    localparam int PHASE_REQS  = 107;
    localparam int PRINT_CAP   = 40;
    localparam int LG_CEIL     = 11;
    localparam int QCOUNT_CEIL = 64;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct packed {
        logic [WORD_W-1:0] remote_ip;
        logic [PORT_W-1:0] remote_port;
        logic [PORT_W-1:0] own_port;
    } flow_req_t;

    typedef struct packed {
        logic [HASH_W-1:0]  hash;
        logic [QUEUE_W-1:0] queue;
    } queue_sel_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [WORD_W-1:0]    remote_ip = '0;
    logic [PORT_W-1:0]    remote_port = '0;
    logic [PORT_W-1:0]    own_port = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [HASH_W-1:0]    hash_value;
    logic [QUEUE_W-1:0]   queue_index;

    // Shadow copy of the configuration registers
    logic [WORD_W-1:0] key_shadow [4];
    logic [WORD_W-1:0] local_ip_shadow;
    logic [LG_W-1:0]   table_lg_shadow;
    logic [QCNT_W-1:0] qcount_shadow;

    flow_req_t  flows_to_send [$];
    queue_sel_t selections_due [$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int idle_pct = 0;
    int send_gap = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit hold_request = 1'b0;
    bit req_taken = 1'b0;

    toeplitz_flow_queue_select u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .remote_ip   (remote_ip),
        .remote_port (remote_port),
        .own_port    (own_port),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hash_value  (hash_value),
        .queue_index (queue_index)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Toeplitz hash over the 96-bit tuple, then table mask and queue modulus
    function automatic queue_sel_t toeplitz_lookup(flow_req_t req);
        logic [127:0]      key_bits;
        logic [95:0]       tuple;
        logic [HASH_W-1:0] acc;
        int unsigned       lg;
        int unsigned       qc;
        int unsigned       masked;
        queue_sel_t        sel;
        key_bits = {key_shadow[0], key_shadow[1], key_shadow[2], key_shadow[3]};
        tuple    = {req.remote_ip, local_ip_shadow, req.remote_port, req.own_port};
        acc      = '0;
        // tuple bit p (MSB first) picks the key window starting at key bit p
        for (int p = 0; p < 96; p++)
        begin
            if (tuple[95 - p])
            begin
                acc = acc ^ key_bits[127 - p -: 32];
            end
        end
        lg = (table_lg_shadow > LG_CEIL) ? LG_CEIL : table_lg_shadow;
        qc = qcount_shadow;
        if (qc == 0)
        begin
            qc = 1;
        end
        else if (qc > QCOUNT_CEIL)
        begin
            qc = QCOUNT_CEIL;
        end
        masked    = acc & ((32'd1 << lg) - 32'd1);
        sel.hash  = acc;
        sel.queue = QUEUE_W'(masked % qc);
        return sel;
    endfunction

    task automatic report_mismatch(string what);
        mismatches++;
        if (mismatches <= PRINT_CAP)
        begin
            $display("check failed at %0t: %s", $time, what);
        end
    endtask

    // One register write; the monitor updates the shadow on the handshake
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic wait_drained();
        while (flows_to_send.size() != 0 || selections_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // Request driver: holds a stalled request, idles in bursts otherwise
    always @(negedge clk)
    begin
        if (!in_valid || req_taken)
        begin
            req_taken = 1'b0;
            if (send_gap != 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                send_gap = $urandom_range(0, 8);
                in_valid <= 1'b0;
            end
            else if (flows_to_send.size() != 0)
            begin
                in_valid    <= 1'b1;
                remote_ip   <= flows_to_send[0].remote_ip;
                remote_port <= flows_to_send[0].remote_port;
                own_port    <= flows_to_send[0].own_port;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result back-pressure: random bursts plus one long hold-off on demand
    always @(negedge clk)
    begin
        if (hold_request)
        begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (stall_left != 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(0, 8);
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Monitor: config shadow, prediction on accept, result check, watchdog
    always @(posedge clk)
    begin
        flow_req_t  req;
        queue_sel_t want;
        bit         traffic;
        traffic = 1'b0;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                traffic = 1'b1;
                case (cfg_index)
                    CFG_KEY0:     key_shadow[0]   = cfg_data;
                    CFG_KEY1:     key_shadow[1]   = cfg_data;
                    CFG_KEY2:     key_shadow[2]   = cfg_data;
                    CFG_KEY3:     key_shadow[3]   = cfg_data;
                    CFG_LOCAL_IP: local_ip_shadow = cfg_data;
                    CFG_TABLE_LG: table_lg_shadow = cfg_data[LG_W-1:0];
                    CFG_QCOUNT:   qcount_shadow   = cfg_data[QCNT_W-1:0];
                    default:      ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                traffic         = 1'b1;
                req.remote_ip   = remote_ip;
                req.remote_port = remote_port;
                req.own_port    = own_port;
                selections_due.push_back(toeplitz_lookup(req));
                void'(flows_to_send.pop_front());
                req_taken = 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                traffic = 1'b1;
                if (selections_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result hash %h queue %0d",
                                              hash_value, queue_index));
                end
                else
                begin
                    want = selections_due.pop_front();
                    if (hash_value !== want.hash)
                    begin
                        report_mismatch($sformatf("hash_value %h, want %h",
                                                  hash_value, want.hash));
                    end
                    if (queue_index !== want.queue)
                    begin
                        report_mismatch($sformatf("queue_index %0d, want %0d (hash %h)",
                                                  queue_index, want.queue, want.hash));
                    end
                end
            end
            quiet_cycles = traffic ? 0 : quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("toeplitz_flow_queue_select: mismatch");
            $finish;
        end
    end

    // Stimulus: directed flows on reset config, then randomized config phases
    initial
    begin
        flow_req_t        f;
        logic [WORD_W-1:0] lg_data;
        logic [WORD_W-1:0] qc_data;
        logic [WORD_W-1:0] keys [4];
        logic [WORD_W-1:0] lip;
        key_shadow[0]   = KEY0_RESET;
        key_shadow[1]   = KEY1_RESET;
        key_shadow[2]   = KEY2_RESET;
        key_shadow[3]   = KEY3_RESET;
        local_ip_shadow = '0;
        table_lg_shadow = TABLE_LG_RESET;
        qcount_shadow   = QCOUNT_RESET;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed flows: empty tuple, all-ones request fields, first and last tuple bits
        idle_pct = 20;
        flows_to_send.push_back('{32'h0000_0000, 16'h0000, 16'h0000});
        flows_to_send.push_back('{32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF});
        flows_to_send.push_back('{32'h8000_0000, 16'h0000, 16'h0000});
        flows_to_send.push_back('{32'h0000_0001, 16'h0000, 16'h0000});
        flows_to_send.push_back('{32'h0000_0000, 16'h8000, 16'h0000});
        flows_to_send.push_back('{32'h0000_0000, 16'h0001, 16'h0000});
        flows_to_send.push_back('{32'h0000_0000, 16'h0000, 16'h8000});
        flows_to_send.push_back('{32'h0000_0000, 16'h0000, 16'h0001});
        flows_to_send.push_back('{32'hFFFF_FFFF, 16'h0000, 16'h0000});
        flows_to_send.push_back('{32'h0000_0000, 16'hFFFF, 16'hFFFF});
        flows_to_send.push_back('{32'hAAAA_AAAA, 16'h5555, 16'hAAAA});
        flows_to_send.push_back('{32'h5555_5555, 16'hAAAA, 16'h5555});
        flows_to_send.push_back('{32'hC0A8_0001, 16'd443, 16'd50000});
        flows_to_send.push_back('{32'h0A00_0002, 16'd80, 16'd1024});
        for (int n = 0; n < 6; n++)
        begin
            f.remote_ip   = $urandom();
            f.remote_port = PORT_W'($urandom());
            f.own_port    = PORT_W'($urandom());
            flows_to_send.push_back(f);
        end
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++)
        begin
            // per-phase idling; no idling in the closing phases
            case (ph)
                0:       idle_pct = 20;
                1:       idle_pct = 0;
                2:       idle_pct = 40;
                3:       idle_pct = 10;
                4:       idle_pct = 30;
                5:       idle_pct = 15;
                6:       idle_pct = 0;
                7:       idle_pct = 50;
                8:       idle_pct = 25;
                9:       idle_pct = 10;
                default: idle_pct = 0;
            endcase

            for (int k = 0; k < 4; k++)
            begin
                keys[k] = $urandom();
            end
            lip     = $urandom();
            lg_data = $urandom_range(0, 1) ? $urandom() : '0;
            qc_data = $urandom_range(0, 1) ? $urandom() : '0;
            lg_data[LG_W-1:0]   = LG_W'($urandom_range(0, 15));
            qc_data[QCNT_W-1:0] = QCNT_W'($urandom_range(0, 127));
            case (ph)
                0:
                begin
                    // zero key, zero queue count, no table bits
                    keys = '{default: '0};
                    lip  = '1;
                    lg_data[LG_W-1:0]   = 4'd0;
                    qc_data[QCNT_W-1:0] = 7'd0;
                end
                1:
                begin
                    // all-ones key, both table and queue count saturate
                    keys = '{default: '1};
                    lip  = '0;
                    lg_data[LG_W-1:0]   = 4'd15;
                    qc_data[QCNT_W-1:0] = 7'd127;
                end
                2:
                begin
                    lg_data[LG_W-1:0]   = 4'd12;
                    qc_data[QCNT_W-1:0] = 7'd64;
                end
                3:
                begin
                    lg_data[LG_W-1:0]   = 4'd11;
                    qc_data[QCNT_W-1:0] = 7'd65;
                end
                4:
                begin
                    lg_data[LG_W-1:0]   = 4'd1;
                    qc_data[QCNT_W-1:0] = 7'd3;
                end
                5:
                begin
                    keys = '{KEY0_RESET, KEY1_RESET, KEY2_RESET, KEY3_RESET};
                    lg_data[LG_W-1:0]   = 4'd11;
                    qc_data[QCNT_W-1:0] = 7'd63;
                end
                default: ;
            endcase
            write_reg(CFG_KEY0, keys[0]);
            write_reg(CFG_KEY1, keys[1]);
            write_reg(CFG_UNUSED, $urandom());
            write_reg(CFG_KEY2, keys[2]);
            write_reg(CFG_KEY3, keys[3]);
            write_reg(CFG_LOCAL_IP, lip);
            write_reg(CFG_TABLE_LG, lg_data);
            write_reg(CFG_QCOUNT, qc_data);
            @(negedge clk);
            cfg_valid <= 1'b0;

            // fill the pipeline against a long result hold-off once
            if (ph == 3)
            begin
                hold_request = 1'b1;
            end

            for (int n = 0; n < PHASE_REQS; n++)
            begin
                f.remote_ip   = $urandom();
                f.remote_port = PORT_W'($urandom());
                f.own_port    = PORT_W'($urandom());
                case ($urandom_range(0, 11))
                    0: f.remote_ip   = '0;
                    1: f.remote_ip   = '1;
                    2: f.remote_ip   = 32'd1 << $urandom_range(0, 31);
                    3: f.remote_port = '0;
                    4: f.remote_port = '1;
                    5: f.own_port    = 16'd1 << $urandom_range(0, 15);
                    6: f.own_port    = '1;
                    default: ;
                endcase
                flows_to_send.push_back(f);
            end
            wait_drained();
        end

        if (mismatches == 0)
        begin
            $display("toeplitz_flow_queue_select: match");
        end
        else
        begin
            $display("toeplitz_flow_queue_select: mismatch");
        end
        $finish;
    end

endmodule
